// ----- rtl/vcc_pkg.sv -----
// Package for the vending credit and change unit: payload structs, codes,
// denomination table and controller/datapath command types. No dependencies.
package vcc_pkg;

    localparam int NDEN = 5;
    localparam logic [7:0] STOCK_MAX = 8'd255;
    localparam logic [9:0] COIN_MAX = 10'd1023;
    localparam logic [4:0] PAY_MAX = 5'd31;
    localparam logic [13:0] CREDIT_MAX = 14'd16383;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_SELECT = 3'd1;
    localparam logic [2:0] CMD_REFUND = 3'd2;
    localparam logic [2:0] CMD_STOCK  = 3'd3;
    localparam logic [2:0] CMD_COIN   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LIMIT   = 3'd1;
    localparam logic [2:0] ST_CREDIT  = 3'd2;
    localparam logic [2:0] ST_SOLDOUT = 3'd3;
    localparam logic [2:0] ST_NOCHG   = 3'd4;

    localparam logic [2:0] REG_PRICE_E   = 3'd4;
    localparam logic [2:0] REG_COIN_LIM  = 3'd5;
    localparam logic [2:0] REG_BILL_LIM  = 3'd6;
    localparam logic [2:0] REG_KEEP      = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] slot;
        logic [9:0] load_value;
    } vcc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  short_denom;
        logic [13:0] credit;
        logic        vended;
        logic [2:0]  vended_product;
        logic [4:0]  paid_ten;
        logic [4:0]  paid_fifty;
        logic [4:0]  paid_hundred;
        logic [4:0]  paid_five_hundred;
        logic [4:0]  paid_thousand;
    } vcc_out_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SUM, S_CHECK, S_GREEDY, S_COMMIT, S_OUT
    } vcc_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;  // latch input beat
        logic sum_start;  // clear accumulator, index 0
        logic sum_step;   // add one denomination
        logic check;      // simple commands and select checks
        logic greedy_init;
        logic greedy_step;
        logic commit;
        logic finish;     // credit sum finished, build result
        logic recount;    // start post-update credit sum
    } vcc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sum_last;
        logic is_select_go;
        logic greedy_done;
    } vcc_stat_t;

    function automatic logic [10:0] denom_value(input logic [2:0] i);
        case (i)
            3'd0: denom_value = 11'd10;
            3'd1: denom_value = 11'd50;
            3'd2: denom_value = 11'd100;
            3'd3: denom_value = 11'd500;
            3'd4: denom_value = 11'd1000;
            default: denom_value = 11'd0;
        endcase
    endfunction

endpackage

// ----- rtl/vending_credit_and_change_unit.sv -----
// Top level of the vending credit and change unit: joins controller and
// datapath. Depends on vcc_pkg, vcc_ctrl, vcc_datapath.
//
// Use: one command beat enters on s_valid/s_ready (insert, select, refund,
// set stock, set coin count) and exactly one result beat leaves on
// m_valid/m_ready with status, credit, vend flag and coins paid out.
// Configuration (prices, insert limits, keep threshold) is written on cfg_we/
// cfg_index/cfg_data by the user only while idle, not enforced; no read-back.
//
// After the command beat the unit runs the credit sum over the denominations
// (S_SUM), a check (S_CHECK), the commit (S_COMMIT), the credit recount (S_SUM
// again) and then offers the result (S_OUT); once it is taken the unit returns
// to S_IDLE before the next command is taken. A select that passes the price
// and stock checks adds the greedy change walk (S_GREEDY) between check and
// commit, one coin or one denomination step per cycle.
// The credit adder and the greedy unit are shared, one term per cycle.
// Throughput: one beat at a time; s_ready is high only when idle.
//
// Reset: aresetn low clears stock, coin inventory and inserted coins and
// restores the default configuration. If the receiver stalls, hold the
// result on m_data until taken; no new command is accepted meanwhile.
module vending_credit_and_change_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vcc_pkg::vcc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output vcc_pkg::vcc_out_t m_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [13:0]       cfg_data
);
    import vcc_pkg::*;

    vcc_cmd_t  cmd;
    vcc_stat_t stat;

    vcc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .stat
    );

    vcc_datapath u_dp (
        .aclk, .aresetn, .s_data, .cfg_we, .cfg_index, .cfg_data,
        .cmd, .stat, .m_data
    );
endmodule

// ----- rtl/vcc_ctrl.sv -----
// Controller state machine for the vending credit and change unit.
// Depends on vcc_pkg.
module vcc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output vcc_pkg::vcc_cmd_t  cmd,
    input  vcc_pkg::vcc_stat_t stat
);
    import vcc_pkg::*;

    vcc_state_t state_reg, state_next;
    logic       post_reg, post_next;  // second credit sum after the update

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            post_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            post_reg  <= post_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        post_next  = post_reg;
        case (state_reg)
            S_IDLE: if (s_valid) begin
                state_next = S_SUM;
                post_next  = 1'b0;
            end
            S_SUM: if (stat.sum_last) begin
                if (post_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: state_next = stat.is_select_go ? S_GREEDY : S_COMMIT;
            S_GREEDY: if (stat.greedy_done) state_next = S_COMMIT;
            S_COMMIT: begin
                state_next = S_SUM;
                post_next  = 1'b1;
            end
            S_OUT: if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
                cmd.sum_start = s_valid;
            end
            S_SUM: begin
                cmd.sum_step = 1'b1;
                cmd.finish   = stat.sum_last & post_reg;
            end
            S_CHECK: begin
                cmd.check       = 1'b1;
                cmd.greedy_init = stat.is_select_go;
            end
            S_GREEDY: cmd.greedy_step = 1'b1;
            S_COMMIT: begin
                cmd.commit  = 1'b1;
                cmd.recount = 1'b1;
            end
            S_OUT: m_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ----- rtl/vcc_datapath.sv -----
// Datapath for the vending credit and change unit: state arrays, credit
// accumulator, greedy change unit and result register. Depends on vcc_pkg.
module vcc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  vcc_pkg::vcc_in_t   s_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [13:0]        cfg_data,
    input  vcc_pkg::vcc_cmd_t  cmd,
    output vcc_pkg::vcc_stat_t stat,
    output vcc_pkg::vcc_out_t  m_data
);
    import vcc_pkg::*;

    logic [8:0]  price_reg [5];
    logic [4:0]  coin_lim_reg, bill_lim_reg;
    logic [13:0] keep_reg;
    logic [7:0]  stock_reg [NDEN];
    logic [9:0]  inv_reg   [NDEN];
    logic [4:0]  ins_reg   [NDEN];
    logic [4:0]  take_reg  [NDEN];
    vcc_in_t     item_reg;
    logic [15:0] acc_reg;      // max 31*1660 fits 16 bits
    logic [15:0] total_reg;
    logic [15:0] rem_reg;
    logic [2:0]  idx_reg;
    logic [2:0]  gidx_reg;
    logic [2:0]  flag_reg;
    logic        go_reg;       // select passed checks
    logic        fail_reg;
    logic [2:0]  st_reg, sd_reg;
    logic        vend_reg;
    logic [4:0]  paid_reg  [NDEN];
    vcc_out_t    out_reg;

    logic [2:0]  sl;
    logic [8:0]  price;
    logic [4:0]  lim;
    logic        slot_ok;
    logic [10:0] gd;
    logic [15:0] prod;
    logic        can_take;     // one more coin of this denomination may leave

    assign sl      = item_reg.slot;
    assign slot_ok = sl < 3'd5;
    assign price   = price_reg[slot_ok ? sl : 3'd0];
    assign lim     = (sl == 3'd4) ? bill_lim_reg : coin_lim_reg;
    assign gd      = denom_value(gidx_reg);
    assign prod    = 16'(denom_value(idx_reg)) * 16'(ins_reg[idx_reg]);
    assign can_take = 10'(take_reg[gidx_reg]) < inv_reg[gidx_reg]
                      && take_reg[gidx_reg] < PAY_MAX;

    assign stat.sum_last     = idx_reg == 3'd4;
    assign stat.is_select_go = slot_ok && item_reg.command == CMD_SELECT
                               && 16'(price) <= total_reg && stock_reg[sl] != 8'd0;
    // done at the lowest denomination once nothing more can be paid from it
    assign stat.greedy_done  = gidx_reg == 3'd0 && (rem_reg < 16'(gd) || !can_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) price_reg[i] <= 9'd100;
            coin_lim_reg <= 5'd20;
            bill_lim_reg <= 5'd2;
            keep_reg     <= 14'd110;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COIN_LIM: coin_lim_reg <= cfg_data[4:0];
                REG_BILL_LIM: bill_lim_reg <= cfg_data[4:0];
                REG_KEEP:     keep_reg     <= cfg_data;
                default:      price_reg[cfg_index] <= cfg_data[8:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NDEN; i++) begin
                stock_reg[i] <= '0;
                inv_reg[i]   <= '0;
                ins_reg[i]   <= '0;
            end
        end else if (cmd.commit && slot_ok) begin
            case (item_reg.command)
                CMD_INSERT: if (6'(ins_reg[sl]) + 6'd1 <= 6'(lim))
                    ins_reg[sl] <= ins_reg[sl] + 5'd1;
                CMD_SELECT: if (go_reg && !fail_reg) begin
                    for (int i = 0; i < NDEN; i++) begin
                        logic [10:0] c;
                        c = 11'(inv_reg[i]) + 11'(ins_reg[i]) - 11'(take_reg[i]);
                        inv_reg[i] <= (c > 11'(COIN_MAX)) ? COIN_MAX : c[9:0];
                        ins_reg[i] <= (16'(total_reg - 16'(price)) >= 16'(keep_reg))
                                      ? take_reg[i] : 5'd0;
                    end
                    stock_reg[sl] <= stock_reg[sl] - 8'd1;
                end
                CMD_REFUND: for (int i = 0; i < NDEN; i++) ins_reg[i] <= '0;
                CMD_STOCK: stock_reg[sl] <= (item_reg.load_value > 10'(STOCK_MAX))
                                            ? STOCK_MAX : item_reg.load_value[7:0];
                CMD_COIN: inv_reg[sl] <= (item_reg.load_value > COIN_MAX)
                                         ? COIN_MAX : item_reg.load_value;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) item_reg <= s_data;
        if (cmd.sum_start || cmd.recount) begin
            acc_reg <= '0;
            idx_reg <= '0;
        end else if (cmd.sum_step) begin
            acc_reg <= acc_reg + prod;
            if (stat.sum_last) total_reg <= acc_reg + prod;
            else idx_reg <= idx_reg + 3'd1;
        end
        if (cmd.check) begin
            go_reg   <= stat.is_select_go;
            fail_reg <= 1'b0;
            flag_reg <= '0;
            st_reg   <= ST_OK;
            sd_reg   <= '0;
            vend_reg <= 1'b0;
            for (int i = 0; i < NDEN; i++) begin
                take_reg[i] <= '0;
                paid_reg[i] <= '0;
            end
            if (slot_ok) begin
                case (item_reg.command)
                    CMD_INSERT: if (6'(ins_reg[sl]) + 6'd1 > 6'(lim)) begin
                        st_reg <= ST_LIMIT;
                        sd_reg <= sl;
                    end
                    CMD_SELECT:
                        if (16'(price) > total_reg) st_reg <= ST_CREDIT;
                        else if (stock_reg[sl] == 8'd0) st_reg <= ST_SOLDOUT;
                    CMD_REFUND: for (int i = 0; i < NDEN; i++) paid_reg[i] <= ins_reg[i];
                    default: ;
                endcase
            end
        end
        if (cmd.greedy_init) begin
            rem_reg  <= total_reg - 16'(price);
            gidx_reg <= 3'd4;
        end else if (cmd.greedy_step) begin
            // one coin, or one move down a denomination, per cycle
            if (rem_reg >= 16'(gd)) begin
                if (can_take) begin
                    take_reg[gidx_reg] <= take_reg[gidx_reg] + 5'd1;
                    rem_reg <= rem_reg - 16'(gd);
                end else begin
                    flag_reg <= gidx_reg;
                    if (gidx_reg != 3'd0) gidx_reg <= gidx_reg - 3'd1;
                end
            end else if (gidx_reg != 3'd0) begin
                gidx_reg <= gidx_reg - 3'd1;
            end
            if (stat.greedy_done) begin
                if (rem_reg != 16'd0) begin
                    fail_reg <= 1'b1;
                    st_reg   <= ST_NOCHG;
                    // if the lowest denomination runs short in this very cycle, name it; else flag_reg
                    sd_reg   <= (rem_reg >= 16'(gd)) ? gidx_reg : flag_reg;
                end else begin
                    vend_reg <= 1'b1;
                    if (16'(total_reg - 16'(price)) < 16'(keep_reg))
                        for (int i = 0; i < NDEN; i++) paid_reg[i] <= take_reg[i];
                end
            end
        end
        if (cmd.finish) begin
            out_reg.status            <= st_reg;
            out_reg.short_denom       <= sd_reg;
            out_reg.credit            <= ((acc_reg + prod) > 16'(CREDIT_MAX))
                                         ? CREDIT_MAX : 14'(acc_reg + prod);
            out_reg.vended            <= vend_reg;
            out_reg.vended_product    <= vend_reg ? sl : 3'd0;
            out_reg.paid_ten          <= paid_reg[0];
            out_reg.paid_fifty        <= paid_reg[1];
            out_reg.paid_hundred      <= paid_reg[2];
            out_reg.paid_five_hundred <= paid_reg[3];
            out_reg.paid_thousand     <= paid_reg[4];
        end
    end

    assign m_data = out_reg;
endmodule

// ----- rtl/vcc_checker.sv -----
// Port-level checker for the vending credit and change unit, bound to the
// top level. Depends on vcc_pkg.
module vcc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input vcc_pkg::vcc_out_t m_data
);
    import vcc_pkg::*;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped under stall");
    a_vend_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.vended |-> m_data.status == ST_OK)
        else $error("vend with error status");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");
endmodule

bind vending_credit_and_change_unit vcc_checker u_vcc_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);
